// File: hdl/srlr_pkg.sv
// Shared types and constants for the stepper ramp / limit reversal block.
// Used by srlr_cfg, srlr_ctrl, srlr_dp and stepper_ramp_limit_reverse.
`default_nettype none
package srlr_pkg;

	localparam int CNT_W    = 16;
	localparam int PER_W    = 12;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam int RECALC_INTERVAL = 10;
	localparam int PHASE_W = (RECALC_INTERVAL > 1) ? $clog2(RECALC_INTERVAL) : 1;

	// quotient of the interpolation is always below 2**PER_W
	localparam int DIV_STEPS = PER_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int PROD_W    = CNT_W + PER_W;

	localparam logic [CNT_W-1:0]  RST_ACCEL_COUNT   = 16'd1000;
	localparam logic [CNT_W-1:0]  RST_DECEL_START   = 16'd10300;
	localparam logic [CNT_W-1:0]  RST_DECEL_END     = 16'd10800;
	localparam logic [PER_W-1:0]  RST_START_PERIOD  = 12'd90;
	localparam logic [PER_W-1:0]  RST_CRUISE_PERIOD = 12'd20;
	localparam logic [PER_W-1:0]  RST_STOP_PERIOD   = 12'd100;
	localparam logic [BYTE_W-1:0] RST_RESUME_CODE   = 8'd9;
	localparam logic [BYTE_W-1:0] RST_PULSES        = 8'd10;
	localparam logic [PER_W-1:0]  RST_PERIOD_NOW    = 12'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_COUNT   = 3'd0,
		REG_DECEL_START   = 3'd1,
		REG_DECEL_END     = 3'd2,
		REG_START_PERIOD  = 3'd3,
		REG_CRUISE_PERIOD = 3'd4,
		REG_STOP_PERIOD   = 3'd5,
		REG_RESUME_CODE   = 3'd6,
		REG_PULSES        = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  accel_count;
		logic [CNT_W-1:0]  decel_start;
		logic [CNT_W-1:0]  decel_end;
		logic [PER_W-1:0]  start_period;
		logic [PER_W-1:0]  cruise_period;
		logic [PER_W-1:0]  stop_period;
		logic [BYTE_W-1:0] resume_code;
		logic [BYTE_W-1:0] pulses_per_burst;
	} cfg_t;

	typedef struct packed {
		logic in_load;
		logic commit;
		logic mul;
		logic div_init;
		logic div_step;
		logic period_load;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic recalc;
	} dp_status_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_DINIT  = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_FIN    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

// File: hdl/srlr_cfg.sv
// Configuration register file with reset values.
// Depends on srlr_pkg.
`default_nettype none
module srlr_cfg
	import srlr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_count      <= RST_ACCEL_COUNT;
			cfg_q.decel_start      <= RST_DECEL_START;
			cfg_q.decel_end        <= RST_DECEL_END;
			cfg_q.start_period     <= RST_START_PERIOD;
			cfg_q.cruise_period    <= RST_CRUISE_PERIOD;
			cfg_q.stop_period      <= RST_STOP_PERIOD;
			cfg_q.resume_code      <= RST_RESUME_CODE;
			cfg_q.pulses_per_burst <= RST_PULSES;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_ACCEL_COUNT:   cfg_q.accel_count      <= wr_data[CNT_W-1:0];
				REG_DECEL_START:   cfg_q.decel_start      <= wr_data[CNT_W-1:0];
				REG_DECEL_END:     cfg_q.decel_end        <= wr_data[CNT_W-1:0];
				REG_START_PERIOD:  cfg_q.start_period     <= wr_data[PER_W-1:0];
				REG_CRUISE_PERIOD: cfg_q.cruise_period    <= wr_data[PER_W-1:0];
				REG_STOP_PERIOD:   cfg_q.stop_period      <= wr_data[PER_W-1:0];
				REG_RESUME_CODE:   cfg_q.resume_code      <= wr_data[BYTE_W-1:0];
				REG_PULSES:        cfg_q.pulses_per_burst <= wr_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: hdl/srlr_ctrl.sv
// Sequencing FSM: accept, decide, multiply, iterative divide, output load.
// Depends on srlr_pkg.
`default_nettype none
module srlr_ctrl
	import srlr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire dp_status_t st,
	output dp_cmd_t   cmd
);

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.in_load = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.commit = 1'b1;
				state_d = st.recalc ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.period_load = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) div_cnt_q <= '0;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/srlr_dp.sv
// Datapath: travel state, limit edge detect, ramp interpolation
// (multiply, restoring divide) and the result word register. Depends on srlr_pkg.
`default_nettype none
module srlr_dp
	import srlr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 st,
	input  wire logic                  in_cmd,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	output logic      [OUT_DATA_W-1:0] out_data
);

	// item
	logic              kind_q, lim_a_q, lim_b_q;
	logic [BYTE_W-1:0] rbyte_q;

	// travel state
	logic               dir_q, last_a_q, last_b_q, wait_q, burst_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PER_W-1:0]   period_q;

	// interpolation
	logic [CNT_W-1:0]  op_dc_q, op_den_q;
	logic [PER_W-1:0]  op_mag_q, op_p0_q;
	logic              op_neg_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  rem_q;
	logic [PER_W-1:0]  dq_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic run, rev, resume, acc_win, dec_win;
	logic [CNT_W-1:0] dc_d, den_d;
	logic [PER_W-1:0] p0_d, p1_d, mag_d;
	logic [PER_W:0]   dp_d;
	logic [PHASE_W-1:0] phase_d;
	logic [CNT_W:0]   trial, diff;
	logic             ge;

	assign run    = !kind_q && !wait_q;
	assign rev    = run && ((lim_a_q && !last_a_q && dir_q) || (lim_b_q && !last_b_q && !dir_q));
	assign resume = kind_q && wait_q && (rbyte_q == cfg.resume_code);

	assign acc_win = (cnt_q != '0) && (cnt_q < cfg.accel_count);
	assign dec_win = (cnt_q > cfg.decel_start) && (cnt_q < cfg.decel_end);
	assign st.recalc = run && !rev && (phase_q == '0) && (acc_win || dec_win);

	always_comb begin
		if (dec_win) begin
			dc_d  = cnt_q - cfg.decel_start;
			den_d = cfg.decel_end - cfg.decel_start;
			p0_d  = cfg.cruise_period;
			p1_d  = cfg.stop_period;
		end else begin
			dc_d  = cnt_q;
			den_d = cfg.accel_count;
			p0_d  = cfg.start_period;
			p1_d  = cfg.cruise_period;
		end
		dp_d  = {1'b0, p1_d} - {1'b0, p0_d};
		mag_d = dp_d[PER_W] ? PER_W'(-dp_d) : dp_d[PER_W-1:0];
	end

	// counter phase modulo the recalc interval; 2**16 is not a multiple of it
	always_comb begin
		if (cnt_q == '1 || phase_q == PHASE_W'(RECALC_INTERVAL - 1)) phase_d = '0;
		else phase_d = phase_q + 1'b1;
	end

	assign trial = {rem_q, dq_q[PER_W-1]};
	assign diff  = trial - {1'b0, op_den_q};
	assign ge    = !diff[CNT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b0;
			last_a_q <= 1'b0;
			last_b_q <= 1'b0;
			wait_q   <= 1'b0;
			burst_q  <= 1'b0;
			cnt_q    <= '0;
			phase_q  <= '0;
			period_q <= RST_PERIOD_NOW;
		end else begin
			if (cmd.commit) begin
				burst_q <= run && !rev;
				if (resume) begin
					wait_q <= 1'b0;
					dir_q  <= !dir_q;
				end
				if (run) begin
					last_a_q <= lim_a_q;
					last_b_q <= lim_b_q;
					if (rev) begin
						wait_q  <= 1'b1;
						cnt_q   <= '0;
						phase_q <= '0;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						phase_q <= phase_d;
					end
				end
			end
			if (cmd.period_load)
				period_q <= op_neg_q ? op_p0_q - dq_q : op_p0_q + dq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			kind_q  <= in_cmd;
			lim_a_q <= in_data[0];
			lim_b_q <= in_data[1];
			rbyte_q <= in_data[BYTE_W+1:2];
		end
		if (cmd.commit) begin
			op_dc_q  <= dc_d;
			op_den_q <= den_d;
			op_p0_q  <= p0_d;
			op_mag_q <= mag_d;
			op_neg_q <= dp_d[PER_W];
		end
		if (cmd.mul) prod_q <= op_dc_q * op_mag_q;
		if (cmd.div_init) begin
			rem_q <= prod_q[PROD_W-1:PER_W];
			dq_q  <= prod_q[PER_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[PER_W-2:0], ge};
		end
		if (cmd.out_load)
			out_q <= {wait_q, (burst_q ? cfg.pulses_per_burst : BYTE_W'(0)),
				period_q, burst_q, dir_q, !wait_q};
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// File: hdl/stepper_ramp_limit_reverse.sv
// Stepper travel controller: limit-switch reversal and trapezoidal ramp.
// Top level; instantiates srlr_cfg, srlr_ctrl and srlr_dp. Depends on srlr_pkg.
//
// Input stream (s_axis): one word per tick or radio byte. tuser is the kind
// (0 tick, 1 radio). Every input word gives exactly one output word on m_axis.
// Config channel (cfg_*): index/data writes, always ready. Config writes are to be
// made while idle; the block itself does not enforce it.
// Words that do not recompute the half period go from the decide step straight to
// the output load; when the ramp is recomputed, a multiply comes first, then a
// 12-step restoring divider, one quotient bit per cycle.
// One word is in work at a time; the next input is taken once the previous
// result sits in the output register. A receiver that holds m_axis_tready low
// holds a finished result back, and with it the next input.
// A stalled receiver keeps the output word stable; a finished result waits in
// the datapath until the output register frees up.
// Reset: registers return to defaults, direction 0, not waiting, burst flag
// 0, half period 10, both last switch levels 0.
`default_nettype none
module stepper_ramp_limit_reverse
	import srlr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // limit_a, limit_b, radio_byte[7:0], pad
	input  wire logic                  s_axis_tuser,  // cmd
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // driver_enable, direction, burst,
	                                                  // half_period[11:0], pulse_count[7:0],
	                                                  // waiting
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	srlr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	srlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	srlr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.st       (st),
		.in_cmd   (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule
`default_nettype wire
